>>> rtl/mesh_unit_cube_normalize_assert.svh
// Assertion macros used by the port-level checker file
`ifndef MESH_UNIT_CUBE_NORMALIZE_ASSERT_SVH
`define MESH_UNIT_CUBE_NORMALIZE_ASSERT_SVH

// same-cycle implication
`define MUCN_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define MUCN_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> rtl/mucn_pkg.sv
// Package: types and constants of the unit-cube normaliser
package mucn_pkg;
  localparam int unsigned MAX_VERTICES_DEF = 4096;
  localparam int unsigned QDEPTH = 2;
  localparam logic [16:0] HALF_Q16 = 17'd32768;

  typedef enum logic {
    CMD_LOAD = 1'b0,
    CMD_READ = 1'b1
  } cmd_e;

  typedef struct packed {
    logic               cmd;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic [11:0]        read_index;
  } in_item_t;

  typedef struct packed {
    logic [16:0] norm_x;
    logic [16:0] norm_y;
    logic [16:0] norm_z;
    logic        degenerate;
    logic        bad_index;
  } out_item_t;

  typedef struct packed {
    cmd_e               op;
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] pz;
    logic [11:0]        idx;
  } q_entry_t;

  typedef struct packed {
    logic push;
    logic full;
  } q_ctrl_t;
endpackage

>>> rtl/mucn_front.sv
// Front end: takes input transactions and classifies them into queue entries
module mucn_front import mucn_pkg::*; (
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  in_item_t in_data_i,
  input  logic     q_full_i,
  output q_ctrl_t  q_ctrl_o,
  output q_entry_t q_entry_o
);
  always_comb begin
    in_stall_o       = q_full_i;
    q_ctrl_o.push    = in_valid_i && !q_full_i;
    q_ctrl_o.full    = q_full_i;
    q_entry_o.op     = (in_data_i.cmd == 1'b1) ? CMD_READ : CMD_LOAD;
    q_entry_o.px     = in_data_i.pos_x;
    q_entry_o.py     = in_data_i.pos_y;
    q_entry_o.pz     = in_data_i.pos_z;
    q_entry_o.idx    = in_data_i.read_index;
  end
endmodule

>>> rtl/mucn_fifo.sv
// Short queue between front end and back end
module mucn_fifo import mucn_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  q_ctrl_t  ctrl_i,
  input  q_entry_t entry_i,
  output logic     full_o,
  output logic     empty_o,
  input  logic     pop_i,
  output q_entry_t entry_o
);
  localparam int unsigned PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int unsigned CNW = $clog2(QDEPTH + 1);

  q_entry_t       mem_q [QDEPTH];
  logic [PW-1:0]  wptr_q, rptr_q;
  logic [CNW-1:0] cnt_q;
  logic           do_pop;
  logic           do_push;

  assign full_o  = (cnt_q == CNW'(QDEPTH));
  assign empty_o = (cnt_q == '0);
  assign entry_o = mem_q[rptr_q];
  assign do_pop  = pop_i && !empty_o;
  assign do_push = ctrl_i.push && !ctrl_i.full;

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wptr_q] <= entry_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_push) wptr_q <= (wptr_q == PW'(QDEPTH - 1)) ? '0 : wptr_q + 1'b1;
      if (do_pop) rptr_q <= (rptr_q == PW'(QDEPTH - 1)) ? '0 : rptr_q + 1'b1;
      if (do_push && !do_pop) cnt_q <= cnt_q + 1'b1;
      else if (!do_push && do_pop) cnt_q <= cnt_q - 1'b1;
    end
  end
endmodule

>>> rtl/mucn_back.sv
// Back end: vertex store, bounding box, reciprocal unit and per-axis mapping
module mucn_back import mucn_pkg::*; #(
  parameter int unsigned MAX_VERTICES = MAX_VERTICES_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      q_empty_i,
  input  q_entry_t  q_entry_i,
  output logic      q_pop_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_data_o
);
  localparam int unsigned AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int unsigned CW = $clog2(MAX_VERTICES + 1);
  localparam int unsigned XW = (CW > 12) ? CW : 12;

  typedef enum logic [2:0] {
    ST_IDLE, ST_EXT, ST_NORM, ST_DIV, ST_RD, ST_DIFF, ST_MUL, ST_OUT
  } state_e;

  logic [31:0] mem_x [MAX_VERTICES];
  logic [31:0] mem_y [MAX_VERTICES];
  logic [31:0] mem_z [MAX_VERTICES];
  logic [31:0] rd_q  [3];

  state_e             state_q;
  logic [CW-1:0]      count_q;
  logic signed [31:0] min_q [3];
  logic signed [31:0] max_q [3];
  logic [31:0]        scale_q;
  logic               ready_q;
  logic [5:0]         n_q;
  logic [11:0]        idx_q;
  logic [31:0]        dvs_q, lo_q, quo_q;
  logic [32:0]        rem_q;
  logic [4:0]         k_q, it_q;
  logic               neg_q [3];
  logic [32:0]        mag_q [3];
  logic [64:0]        prod_q [3];
  logic               bad_q, degen_q;
  logic               ovalid_q;
  out_item_t          odata_q;

  logic [CW-1:0]      eff_count;
  logic               load_go, write_en;
  logic [AW-1:0]      waddr, raddr;
  logic [XW-1:0]      idx_ext, cnt_ext;
  logic [31:0]        ext [3];
  logic [31:0]        big;
  logic [32:0]        rem_sh;
  logic signed [33:0] dval [3];
  logic [16:0]        nrm [3];
  logic [65:0]        rsum [3];
  logic [65:0]        qv [3];
  logic [16:0]        qc [3];
  logic               slot_free;
  logic signed [31:0] pin [3];

  assign q_pop_o   = (state_q == ST_IDLE) && !q_empty_i;
  assign load_go   = q_pop_o && (q_entry_i.op == CMD_LOAD);
  assign eff_count = ready_q ? '0 : count_q;
  assign write_en  = load_go && (eff_count != CW'(MAX_VERTICES));
  assign waddr     = eff_count[AW-1:0];
  assign idx_ext   = XW'(idx_q);
  assign cnt_ext   = XW'(count_q);
  assign raddr     = idx_ext[AW-1:0];
  assign slot_free = !ovalid_q || !out_stall_i;
  assign out_valid_o = ovalid_q;
  assign out_data_o  = odata_q;
  assign rem_sh    = {rem_q[31:0], lo_q[31]};
  assign pin[0] = q_entry_i.px;
  assign pin[1] = q_entry_i.py;
  assign pin[2] = q_entry_i.pz;

  always_comb begin
    big = '0;
    for (int a = 0; a < 3; a++) begin
      ext[a] = 32'(33'(max_q[a]) - 33'(min_q[a]));
      dval[a] = ($signed({{2{rd_q[a][31]}}, rd_q[a]}) <<< 1) - 34'(min_q[a]) - 34'(max_q[a]);
      rsum[a] = {1'b0, prod_q[a]} + (66'd1 << (n_q + 6'd15));
      qv[a]   = rsum[a] >> (n_q + 6'd16);
      qc[a]   = (qv[a] > 66'(HALF_Q16)) ? HALF_Q16 : qv[a][16:0];
      nrm[a]  = neg_q[a] ? (HALF_Q16 - qc[a]) : (HALF_Q16 + qc[a]);
    end
    for (int a = 0; a < 3; a++) begin
      if (ext[a] > big) big = ext[a];
    end
  end

  always_ff @(posedge clk_i) begin
    if (write_en) begin
      mem_x[waddr] <= q_entry_i.px;
      mem_y[waddr] <= q_entry_i.py;
      mem_z[waddr] <= q_entry_i.pz;
    end
    rd_q[0] <= mem_x[raddr];
    rd_q[1] <= mem_y[raddr];
    rd_q[2] <= mem_z[raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      count_q  <= '0;
      scale_q  <= '0;
      ready_q  <= 1'b0;
      n_q      <= '0;
      ovalid_q <= 1'b0;
      for (int a = 0; a < 3; a++) begin
        min_q[a] <= '0;
        max_q[a] <= '0;
      end
    end else begin
      if (ovalid_q && !out_stall_i && state_q != ST_OUT) ovalid_q <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          if (load_go) begin
            ready_q <= 1'b0;
            count_q <= eff_count;
            if (write_en) begin
              count_q <= eff_count + 1'b1;
              for (int a = 0; a < 3; a++) begin
                if (eff_count == '0 || pin[a] < min_q[a]) min_q[a] <= pin[a];
                if (eff_count == '0 || pin[a] > max_q[a]) max_q[a] <= pin[a];
              end
            end
          end else if (q_pop_o) begin
            idx_q   <= q_entry_i.idx;
            state_q <= ready_q ? ST_RD : ST_EXT;
          end
        end
        ST_EXT: begin
          if (big == '0) begin
            scale_q <= '0;
            n_q     <= '0;
            ready_q <= 1'b1;
            state_q <= ST_RD;
          end else begin
            dvs_q   <= big;
            k_q     <= '0;
            state_q <= ST_NORM;
          end
        end
        ST_NORM: begin
          if (dvs_q[31]) begin
            rem_q   <= 33'h0_7FFF_FFFF;
            lo_q    <= 32'hFFFF_FFFF << k_q;
            it_q    <= '0;
            state_q <= ST_DIV;
          end else begin
            dvs_q <= dvs_q << 1;
            k_q   <= k_q + 1'b1;
          end
        end
        ST_DIV: begin
          lo_q <= lo_q << 1;
          if (rem_sh >= {1'b0, dvs_q}) begin
            rem_q <= rem_sh - {1'b0, dvs_q};
            quo_q <= {quo_q[30:0], 1'b1};
          end else begin
            rem_q <= rem_sh;
            quo_q <= {quo_q[30:0], 1'b0};
          end
          it_q <= it_q + 1'b1;
          if (it_q == 5'd31) begin
            scale_q <= (rem_sh >= {1'b0, dvs_q}) ? {quo_q[30:0], 1'b1} : {quo_q[30:0], 1'b0};
            n_q     <= 6'd32 - {1'b0, k_q};
            ready_q <= 1'b1;
            state_q <= ST_RD;
          end
        end
        ST_RD: state_q <= ST_DIFF;
        ST_DIFF: begin
          bad_q   <= (idx_ext >= cnt_ext);
          degen_q <= (scale_q == '0);
          for (int a = 0; a < 3; a++) begin
            neg_q[a] <= dval[a][33];
            mag_q[a] <= dval[a][33] ? 33'(-dval[a]) : dval[a][32:0];
          end
          state_q <= ST_MUL;
        end
        ST_MUL: begin
          for (int a = 0; a < 3; a++) prod_q[a] <= mag_q[a] * 65'(scale_q);
          state_q <= ST_OUT;
        end
        ST_OUT: begin
          if (slot_free) begin
            ovalid_q <= 1'b1;
            if (bad_q) begin
              odata_q <= '{norm_x: '0, norm_y: '0, norm_z: '0, degenerate: 1'b0,
                           bad_index: 1'b1};
            end else if (degen_q) begin
              odata_q <= '{norm_x: HALF_Q16, norm_y: HALF_Q16, norm_z: HALF_Q16,
                           degenerate: 1'b1, bad_index: 1'b0};
            end else begin
              odata_q <= '{norm_x: nrm[0], norm_y: nrm[1], norm_z: nrm[2],
                           degenerate: 1'b0, bad_index: 1'b0};
            end
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end
endmodule

>>> rtl/mesh_unit_cube_normalize.sv
// Top level of the unit-cube normaliser
// Usage:
//   Input channel in_valid_i / in_stall_o / in_data_i carries load (cmd 0) and
//   read (cmd 1) transactions. Output channel out_valid_o / out_stall_i /
//   out_data_o returns one transaction per read, none per load.
//   A two-entry queue separates the input side from the execution engine.
// Throughput and sequence:
//   Loads retire one per cycle while the engine is idle. A read passes from the
//   queue through vertex store read, difference, multiply and rounding to the
//   output register. The first read after a load burst also runs the reciprocal
//   unit first: an extent step, a normalising shift and a restoring division;
//   a flat box with zero extent skips the shift and the division.
// Reset:
//   Vertex count, bounding box, scale and all handshake state clear; the store
//   contents stay undefined and are never used for a result before being written.
// Back-pressure:
//   While out_stall_i is high the result holds; the engine waits, the queue
//   fills and in_stall_o rises once both entries are taken.
module mesh_unit_cube_normalize import mucn_pkg::*; #(
  parameter int unsigned MAX_VERTICES = MAX_VERTICES_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_data_o
);
  q_ctrl_t  q_ctrl;
  q_entry_t q_in, q_out;
  logic     q_full, q_empty, q_pop;

  mucn_front u_front (
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .q_full_i   (q_full),
    .q_ctrl_o   (q_ctrl),
    .q_entry_o  (q_in)
  );

  mucn_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (q_ctrl),
    .entry_i (q_in),
    .full_o  (q_full),
    .empty_o (q_empty),
    .pop_i   (q_pop),
    .entry_o (q_out)
  );

  mucn_back #(.MAX_VERTICES(MAX_VERTICES)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (q_empty),
    .q_entry_i   (q_out),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );
endmodule

>>> rtl/mucn_checker.sv
// Port-level checker for the unit-cube normaliser and its bind
`include "mesh_unit_cube_normalize_assert.svh"

module mucn_checker import mucn_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      out_valid_o,
  input logic      out_stall_i,
  input out_item_t out_data_o
);
  `MUCN_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i,
    out_valid_o && $stable(out_data_o))
  `MUCN_ASSERT_NOW(a_bad_zero, clk_i, rst_ni, out_valid_o && out_data_o.bad_index,
    out_data_o.norm_x == '0 && out_data_o.norm_y == '0 &&
    out_data_o.norm_z == '0 && !out_data_o.degenerate)
  `MUCN_ASSERT_NOW(a_degen_half, clk_i, rst_ni, out_valid_o && out_data_o.degenerate,
    out_data_o.norm_x == HALF_Q16 && out_data_o.norm_y == HALF_Q16 &&
    out_data_o.norm_z == HALF_Q16)
  `MUCN_ASSERT_NOW(a_range, clk_i, rst_ni, out_valid_o,
    out_data_o.norm_x <= 17'd65536 && out_data_o.norm_y <= 17'd65536 &&
    out_data_o.norm_z <= 17'd65536)
endmodule

bind mesh_unit_cube_normalize mucn_checker u_mucn_checker (.*);

>>> tb/tb_mesh_unit_cube_normalize.sv
// Testbench for the unit-cube normaliser: directed and random load/read traffic
`timescale 1ns / 1ps

module tb_mesh_unit_cube_normalize;
  import mucn_pkg::*;

  localparam int unsigned NVERT    = 4096;
  localparam int unsigned WD_LIMIT = 20000;
  localparam int unsigned DRAIN    = 100;

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_stall_o;
  in_item_t  in_data_i;
  logic      out_valid_o;
  logic      out_stall_i;
  out_item_t out_data_o;

  mesh_unit_cube_normalize u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  // predictor state
  logic [31:0]    vx_mem [NVERT];
  logic [31:0]    vy_mem [NVERT];
  logic [31:0]    vz_mem [NVERT];
  int unsigned    vert_cnt;
  longint         box_lo [3];
  longint         box_hi [3];
  logic [31:0]    recip;
  bit             recip_fixed;

  out_item_t      pending_norms [$];
  int unsigned    n_errors;
  int unsigned    n_loads, n_reads, n_results, n_bad, n_degen;
  int unsigned    idle_cycles;
  bit             stall_hold;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  task automatic report_mismatch(input string what, input logic [16:0] got,
                                 input logic [16:0] want);
    n_errors++;
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
  endtask

  function automatic int unsigned bitlen(input longint unsigned v);
    int unsigned n;
    n = 0;
    while (v != 0) begin
      n++;
      v = v >> 1;
    end
    return n;
  endfunction

  function automatic logic [16:0] map_coord(input longint p, input int a, input int unsigned n);
    longint          d;
    longint unsigned mag, q;
    d = 2 * p - box_lo[a] - box_hi[a];
    mag = (d < 0) ? longint'(-d) : longint'(d);
    q = (mag * longint'({32'd0, recip}) + (64'd1 << (n + 15))) >> (n + 16);
    if (q > 32768) q = 32768;
    return (d < 0) ? 17'(32768 - q) : 17'(32768 + q);
  endfunction

  // advance the predictor by one accepted transaction
  task automatic predict_norm(input in_item_t it);
    longint          p [3];
    longint unsigned big, e;
    int unsigned     n;
    out_item_t       r;
    if (cmd_e'(it.cmd) == CMD_LOAD) begin
      n_loads++;
      if (recip_fixed) begin
        vert_cnt = 0;
        recip_fixed = 1'b0;
      end
      if (vert_cnt >= NVERT) return;
      p[0] = longint'(it.pos_x);
      p[1] = longint'(it.pos_y);
      p[2] = longint'(it.pos_z);
      vx_mem[vert_cnt] = it.pos_x;
      vy_mem[vert_cnt] = it.pos_y;
      vz_mem[vert_cnt] = it.pos_z;
      for (int a = 0; a < 3; a++) begin
        if (vert_cnt == 0 || p[a] < box_lo[a]) box_lo[a] = p[a];
        if (vert_cnt == 0 || p[a] > box_hi[a]) box_hi[a] = p[a];
      end
      vert_cnt++;
      return;
    end
    n_reads++;
    big = 0;
    for (int a = 0; a < 3; a++) begin
      e = longint'(box_hi[a] - box_lo[a]);
      if (e > big) big = e;
    end
    n = bitlen(big);
    if (!recip_fixed) begin
      recip = (big == 0) ? 32'd0 : 32'(((64'd1 << (n + 31)) - 1) / big);
      recip_fixed = 1'b1;
    end
    r = '0;
    if (it.read_index >= vert_cnt) begin
      r.bad_index = 1'b1;
      n_bad++;
    end else if (big == 0) begin
      r.norm_x = HALF_Q16;
      r.norm_y = HALF_Q16;
      r.norm_z = HALF_Q16;
      r.degenerate = 1'b1;
      n_degen++;
    end else begin
      r.norm_x = map_coord(longint'($signed(vx_mem[it.read_index])), 0, n);
      r.norm_y = map_coord(longint'($signed(vy_mem[it.read_index])), 1, n);
      r.norm_z = map_coord(longint'($signed(vz_mem[it.read_index])), 2, n);
    end
    pending_norms.push_back(r);
  endtask

  function automatic int unsigned gap_len();
    int unsigned k;
    k = $urandom_range(0, 99);
    if (k < 45) return 0;
    if (k < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  // result checker with random back-pressure
  initial begin
    out_item_t want;
    int unsigned hold;
    out_stall_i = 1'b0;
    hold = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i) begin
        n_results++;
        if (pending_norms.size() == 0) begin
          report_mismatch("result with none outstanding", '0, '0);
        end else begin
          want = pending_norms.pop_front();
          if (out_data_o.norm_x !== want.norm_x)
            report_mismatch("norm_x", out_data_o.norm_x, want.norm_x);
          if (out_data_o.norm_y !== want.norm_y)
            report_mismatch("norm_y", out_data_o.norm_y, want.norm_y);
          if (out_data_o.norm_z !== want.norm_z)
            report_mismatch("norm_z", out_data_o.norm_z, want.norm_z);
          if (out_data_o.degenerate !== want.degenerate)
            report_mismatch("degenerate", 17'(out_data_o.degenerate), 17'(want.degenerate));
          if (out_data_o.bad_index !== want.bad_index)
            report_mismatch("bad_index", 17'(out_data_o.bad_index), 17'(want.bad_index));
        end
      end
      @(negedge clk_i);
      if (stall_hold) out_stall_i <= 1'b0;
      else if (hold > 0) begin
        hold--;
        out_stall_i <= 1'b1;
      end else begin
        hold = gap_len();
        out_stall_i <= (hold > 0);
        if (hold > 0) hold--;
      end
    end
  end

  // watchdog on accepted transactions
  initial begin
    idle_cycles = 0;
    forever begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WD_LIMIT) begin
        $display("watchdog: no transaction for %0d cycles", WD_LIMIT);
        $display("FAIL mesh_unit_cube_normalize");
        $finish;
      end
    end
  end

  // send one item; called just after a falling edge, valid left high on return
  task automatic send_item(input in_item_t it);
    int unsigned g;
    g = gap_len();
    repeat (g) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    do @(posedge clk_i); while (in_stall_o);
    predict_norm(it);
    @(negedge clk_i);
  endtask

  task automatic send_load(input logic [31:0] x, input logic [31:0] y, input logic [31:0] z);
    in_item_t it;
    it = '0;
    it.cmd = CMD_LOAD;
    it.pos_x = x;
    it.pos_y = y;
    it.pos_z = z;
    it.read_index = 12'($urandom);
    send_item(it);
  endtask

  task automatic send_read(input logic [11:0] idx);
    in_item_t it;
    it = '0;
    it.cmd = CMD_READ;
    it.pos_x = $urandom;
    it.pos_y = $urandom;
    it.pos_z = $urandom;
    it.read_index = idx;
    send_item(it);
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    stall_hold = 1'b1;
    while (pending_norms.size() != 0) @(negedge clk_i);
    stall_hold = 1'b0;
  endtask

  function automatic logic [31:0] rand_coord(input int unsigned mode);
    case (mode)
      0: return $urandom;
      1: return 32'($signed($urandom_range(0, 2000)) - 1000);
      2: return 32'($signed($urandom_range(0, 262144)) - 131072);
      default: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
    endcase
  endfunction

  task automatic test_empty_read();
    send_read(12'd0);
    send_read(12'hfff);
  endtask

  task automatic test_extremes();
    send_load(32'h80000000, 32'h7fffffff, 32'h0);
    send_load(32'h7fffffff, 32'h80000000, 32'h0);
    send_load(32'h0, 32'hffffffff, 32'h0);
    send_read(12'd0);
    send_read(12'd1);
    send_read(12'd2);
    send_read(12'd3);
    send_read(12'hfff);
  endtask

  task automatic test_degenerate();
    send_load(32'h12345678, 32'hdeadbeef, 32'h1);
    send_load(32'h12345678, 32'hdeadbeef, 32'h1);
    send_read(12'd1);
    send_read(12'd0);
    send_read(12'd2);
    send_load(32'h0, 32'h0, 32'h0);
    send_read(12'd0);
  endtask

  task automatic test_one_axis();
    send_load(32'h00010000, 32'h5, 32'h5);
    send_load(32'hffff0000, 32'h5, 32'h5);
    send_load(32'h00003333, 32'h5, 32'h5);
    send_read(12'd2);
    send_read(12'd0);
    send_read(12'd1);
  endtask

  task automatic test_random_meshes();
    int unsigned nv, nr, mode, sent;
    sent = 0;
    while (sent < 1750) begin
      nv = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2) : $urandom_range(1, 40);
      mode = $urandom_range(0, 3);
      for (int i = 0; i < nv; i++)
        send_load(rand_coord($urandom_range(0, 4) == 0 ? $urandom_range(0, 3) : mode),
                  rand_coord(mode), rand_coord($urandom_range(0, 3)));
      nr = $urandom_range(1, 12);
      for (int i = 0; i < nr; i++) begin
        if ($urandom_range(0, 9) == 0) send_read(12'($urandom));
        else send_read(12'($urandom_range(0, nv + 1)));
      end
      sent += nv + nr;
      if ($urandom_range(0, 15) == 0) drain_results();
    end
  endtask

  initial begin
    n_errors = 0;
    n_loads = 0;
    n_reads = 0;
    n_results = 0;
    n_bad = 0;
    n_degen = 0;
    vert_cnt = 0;
    recip = '0;
    recip_fixed = 1'b0;
    stall_hold = 1'b0;
    for (int a = 0; a < 3; a++) begin
      box_lo[a] = 0;
      box_hi[a] = 0;
    end
    in_valid_i = 1'b0;
    in_data_i = '0;
    rst_ni = 1'b0;
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_empty_read();
    test_extremes();
    test_degenerate();
    test_one_axis();
    drain_results();
    test_random_meshes();
    drain_results();
    repeat (DRAIN) @(negedge clk_i);
    $display("covered %0d loads and %0d reads, %0d results checked", n_loads, n_reads,
             n_results);
    $display("out-of-range reads %0d, flat meshes %0d", n_bad, n_degen);
    if (n_errors == 0 && pending_norms.size() == 0) begin
      $display("PASS mesh_unit_cube_normalize");
    end else begin
      $display("FAIL mesh_unit_cube_normalize");
    end
    $finish;
  end
endmodule
